>>> rtl/dual_channel_average_watchdog_top_defines.svh
// assertion helpers shared by the rtl that checks itself
`ifndef DUAL_CHANNEL_AVERAGE_WATCHDOG_TOP_DEFINES_SVH
`define DUAL_CHANNEL_AVERAGE_WATCHDOG_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DCAW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dcaw check failed");

// next-cycle implication, checked outside reset
`define DCAW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dcaw check failed");

`endif

>>> rtl/dcaw_pkg.sv
package dcaw_pkg;

   localparam int FIELD_BITS           = 12;
   localparam int LOG2_AVERAGE_DEFAULT = 2;
   localparam int SAMPLE_BITS_DEFAULT  = 12;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam int REQ_DATA_BITS = 16;
   localparam int RSP_DATA_BITS = 32;

   // register index, taken from paddr[3:2]
   localparam logic [1:0] REG_LOW_LIMIT       = 2'd0;
   localparam logic [1:0] REG_HIGH_LIMIT      = 2'd1;
   localparam logic [1:0] REG_WATCHDOG_ENABLE = 2'd2;

   localparam logic [FIELD_BITS-1:0] LOW_LIMIT_RESET  = '0;
   localparam logic [FIELD_BITS-1:0] HIGH_LIMIT_RESET = '1;

   // item mode
   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_REARM  = 1'b1;

   typedef struct packed {
      logic [FIELD_BITS-1:0] low_limit;
      logic [FIELD_BITS-1:0] high_limit;
      logic                  enable;
   } cfg_type;

   typedef struct packed {
      logic                  mode;
      logic [FIELD_BITS-1:0] sample;
   } item_type;

   typedef struct packed {
      logic alarm;
      logic armed;
   } wd_status_type;

endpackage

>>> rtl/dcaw_csr.sv
module dcaw_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [dcaw_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [dcaw_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [dcaw_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready,
   output dcaw_pkg::cfg_type                  cfg
);
   import dcaw_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       write_en;
   logic [1:0] reg_index;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[3:2];
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            REG_LOW_LIMIT:       cfg_in.low_limit  = csr_pwdata[FIELD_BITS-1:0];
            REG_HIGH_LIMIT:      cfg_in.high_limit = csr_pwdata[FIELD_BITS-1:0];
            REG_WATCHDOG_ENABLE: cfg_in.enable     = csr_pwdata[0];
            default:             cfg_in            = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_LOW_LIMIT:       csr_prdata = CSR_DATA_BITS'(cfg_ff.low_limit);
         REG_HIGH_LIMIT:      csr_prdata = CSR_DATA_BITS'(cfg_ff.high_limit);
         REG_WATCHDOG_ENABLE: csr_prdata = CSR_DATA_BITS'(cfg_ff.enable);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_limit  <= LOW_LIMIT_RESET;
         cfg_ff.high_limit <= HIGH_LIMIT_RESET;
         cfg_ff.enable     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/dcaw_accum.sv
module dcaw_accum #(
   parameter int LOG2_AVERAGE = dcaw_pkg::LOG2_AVERAGE_DEFAULT,
   parameter int SAMPLE_W     = dcaw_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [SAMPLE_W-1:0] sample,
   output logic                is_thermal,
   output logic                block_done,
   output logic [SAMPLE_W-1:0] angle_held_in,
   output logic [SAMPLE_W-1:0] thermal_held_in
);
   import dcaw_pkg::*;

   localparam int POS_W = LOG2_AVERAGE + 1;
   localparam int SUM_W = SAMPLE_W + LOG2_AVERAGE;

   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [SUM_W-1:0]    angle_sum_ff, angle_sum_in;
   logic [SUM_W-1:0]    thermal_sum_ff, thermal_sum_in;
   logic [SAMPLE_W-1:0] angle_held_ff, thermal_held_ff;
   logic [SUM_W-1:0]    angle_add, thermal_add;

   // even positions are angle, odd are temperature
   assign is_thermal  = pos_ff[0];
   assign block_done  = step && (&pos_ff);
   assign angle_add   = angle_sum_ff + SUM_W'(sample);
   assign thermal_add = thermal_sum_ff + SUM_W'(sample);

   always_comb begin
      pos_in          = pos_ff;
      angle_sum_in    = angle_sum_ff;
      thermal_sum_in  = thermal_sum_ff;
      angle_held_in   = angle_held_ff;
      thermal_held_in = thermal_held_ff;
      if (step) begin
         pos_in = pos_ff + POS_W'(1);
         if (is_thermal) begin
            thermal_sum_in = thermal_add;
         end else begin
            angle_sum_in = angle_add;
         end
         if (block_done) begin
            // last item of a block is always a temperature sample
            angle_held_in   = SAMPLE_W'(angle_sum_ff >> LOG2_AVERAGE);
            thermal_held_in = SAMPLE_W'(thermal_add >> LOG2_AVERAGE);
            angle_sum_in    = '0;
            thermal_sum_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff          <= '0;
         angle_sum_ff    <= '0;
         thermal_sum_ff  <= '0;
         angle_held_ff   <= '0;
         thermal_held_ff <= '0;
      end else begin
         pos_ff          <= pos_in;
         angle_sum_ff    <= angle_sum_in;
         thermal_sum_ff  <= thermal_sum_in;
         angle_held_ff   <= angle_held_in;
         thermal_held_ff <= thermal_held_in;
      end
   end

endmodule

>>> rtl/dcaw_watchdog.sv
module dcaw_watchdog (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic                            rearm,
   input  logic                            check,
   input  logic [dcaw_pkg::FIELD_BITS-1:0] sample,
   input  dcaw_pkg::cfg_type               cfg,
   output dcaw_pkg::wd_status_type         status
);
   import dcaw_pkg::*;

   logic armed_ff, armed_in;
   logic outside;
   logic trip;

   // crossed limits leave an empty window, so everything is outside
   assign outside = (sample < cfg.low_limit) || (sample > cfg.high_limit);
   assign trip    = step && check && cfg.enable && armed_ff && outside;

   always_comb begin
      armed_in = armed_ff;
      if (step && rearm) begin
         armed_in = 1'b1;
      end else if (trip) begin
         armed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b1;
      end else begin
         armed_ff <= armed_in;
      end
   end

   assign status.alarm = trip;
   assign status.armed = armed_in;

endmodule

>>> rtl/dual_channel_average_watchdog_top.sv
// two-channel block averager with a window watchdog on the temperature channel.
// items arrive as a fixed scan, angle then temperature; every item gives exactly
// one result. after 2^LOG2_AVERAGE scans (2 << LOG2_AVERAGE samples) the result
// carries average_valid and the new averages (each sum >> LOG2_AVERAGE); other
// results repeat the held averages. a temperature sample outside
// [low_limit, high_limit] trips the alarm once when enabled and armed, and
// disarms; a rearm item (tuser = 1) arms again and leaves the averages alone.
// one item per clock is taken while the receiver keeps up; an accepted item
// waits in the input register and then moves to the result register, where its
// result is offered until it is taken; a stalled receiver holds both
// registers. req_tready is combinational from rsp_tready through the two
// registers. registers: low_limit at 0x0, high_limit at 0x4, watchdog_enable at
// 0x8; write them only while no items are in flight.
`include "dual_channel_average_watchdog_top_defines.svh"

module dual_channel_average_watchdog_top #(
   parameter int LOG2_AVERAGE = dcaw_pkg::LOG2_AVERAGE_DEFAULT,
   parameter int SAMPLE_BITS  = dcaw_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // input item stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [dcaw_pkg::REQ_DATA_BITS-1:0] req_tdata,  // [11:0] sample, rest zero
   input  logic                               req_tuser,  // [0] mode
   // result item stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [11:0] angle_average, [23:12] thermal_average, [24] alarm, [25] armed
   output logic [dcaw_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                               rsp_tuser,  // [0] average_valid
   // configuration
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [dcaw_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [dcaw_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [dcaw_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);
   import dcaw_pkg::*;

   // samples are cut to the narrower of the field and the converter
   localparam int SAMPLE_W = (SAMPLE_BITS < FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;

   cfg_type             cfg;
   wd_status_type       wd_status;

   // input register
   logic                s1_valid_ff, s1_valid_in;
   item_type            s1_item_ff;
   logic                req_take;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_user_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                out_load;

   logic [SAMPLE_W-1:0] sample_cut;
   logic                is_thermal;
   logic                block_done;
   logic [SAMPLE_W-1:0] angle_held_in, thermal_held_in;
   logic                sample_step;

   dcaw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // handshake: the result register frees up when empty or being taken
   assign out_load   = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || out_load;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff.mode   <= req_tuser;
         s1_item_ff.sample <= req_tdata[FIELD_BITS-1:0];
      end
      if (out_load) begin
         rsp_user_ff <= block_done;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign sample_cut  = SAMPLE_W'(s1_item_ff.sample);
   assign sample_step = out_load && (s1_item_ff.mode == MODE_SAMPLE);

   dcaw_accum #(
      .LOG2_AVERAGE (LOG2_AVERAGE),
      .SAMPLE_W     (SAMPLE_W)
   ) u_accum (
      .clock           (clock),
      .reset           (reset),
      .step            (sample_step),
      .sample          (sample_cut),
      .is_thermal      (is_thermal),
      .block_done      (block_done),
      .angle_held_in   (angle_held_in),
      .thermal_held_in (thermal_held_in)
   );

   dcaw_watchdog u_watchdog (
      .clock  (clock),
      .reset  (reset),
      .step   (out_load),
      .rearm  (s1_item_ff.mode == MODE_REARM),
      .check  ((s1_item_ff.mode == MODE_SAMPLE) && is_thermal),
      .sample (FIELD_BITS'(sample_cut)),
      .cfg    (cfg),
      .status (wd_status)
   );

   // result packing, lowest field first
   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in[11:0]  = FIELD_BITS'(angle_held_in);
      rsp_data_in[23:12] = FIELD_BITS'(thermal_held_in);
      rsp_data_in[24]    = wd_status.alarm;
      rsp_data_in[25]    = wd_status.armed;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // an alarm always leaves the watchdog disarmed
   `DCAW_ASSERT_NOW(a_alarm_disarms, clock, reset,
      rsp_tvalid && rsp_tdata[24], !rsp_tdata[25])
   // alarms only come from an enabled watchdog
   `DCAW_ASSERT_NOW(a_alarm_enabled, clock, reset,
      rsp_tvalid && rsp_tdata[24], cfg.enable)
   // a rearm item reports neither new averages nor an alarm
   `DCAW_ASSERT_NEXT(a_rearm_quiet, clock, reset,
      out_load && (s1_item_ff.mode == MODE_REARM),
      !rsp_tuser && !rsp_tdata[24] && rsp_tdata[25])
   // an item waiting in the input register is never dropped
   `DCAW_ASSERT_NEXT(a_item_kept, clock, reset,
      s1_valid_ff && !out_load, s1_valid_ff)

endmodule

>>> test/tb_dual_channel_average_watchdog_top.sv
module tb_dual_channel_average_watchdog_top;
   import dcaw_pkg::*;

   localparam int LOG2        = LOG2_AVERAGE_DEFAULT;
   localparam int BLOCK_LEN   = 2 << LOG2;          // angle + temperature per scan
   localparam int SUM_BITS    = FIELD_BITS + LOG2;
   localparam int STALL_LIMIT = 2000;               // cycles with no item moving
   localparam int HOLD_AT     = 300;                // result count that starts the long hold
   localparam int HOLD_CYCLES = 150;
   localparam int DRAIN_WAIT  = 4;                  // input register + result register
   localparam int RAND_PHASES = 8;
   localparam int RAND_ITEMS  = 240;
   localparam int MAX_REPORTS = 10;

   // one result item as the block reports it
   typedef struct packed {
      logic                  average_valid;
      logic [FIELD_BITS-1:0] angle_average;
      logic [FIELD_BITS-1:0] thermal_average;
      logic                  alarm;
      logic                  armed;
   } scan_result_type;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata   = '0;
   logic                     req_tuser   = MODE_SAMPLE;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tuser;
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // stimulus and expectations
   item_type        pending_items[$];
   scan_result_type expected_results[$];
   item_type        current_item;

   // shadow of the block: registers and scan state
   logic [FIELD_BITS-1:0] cfg_low    = LOW_LIMIT_RESET;
   logic [FIELD_BITS-1:0] cfg_high   = HIGH_LIMIT_RESET;
   logic                  cfg_enable = 1'b0;
   int                    scan_pos   = 0;
   logic [SUM_BITS-1:0]   angle_acc  = '0;
   logic [SUM_BITS-1:0]   thermal_acc = '0;
   logic [FIELD_BITS-1:0] angle_held = '0;
   logic [FIELD_BITS-1:0] thermal_held = '0;
   logic                  wd_armed   = 1'b1;

   // idling controls, 0 turns a side's idling off
   int gap_odds    = 0;
   int stall_odds  = 0;
   int gap_left    = 0;
   int stall_left  = 0;
   int hold_left   = 0;
   int results_seen = 0;
   int mismatches  = 0;
   int idle_cycles = 0;

   dual_channel_average_watchdog_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // [11:0] sample, rest zero
      .req_tuser   (req_tuser),   // [0] mode
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      // [11:0] angle_average, [23:12] thermal_average, [24] alarm, [25] armed
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),   // [0] average_valid
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // advances the shadow by one item and returns the result it must produce
   function automatic scan_result_type average_watchdog_step(item_type it);
      scan_result_type r;
      r = '0;
      if (it.mode == MODE_REARM) begin
         // rearm touches nothing but the armed flag
         wd_armed = 1'b1;
      end else begin
         if (scan_pos % 2 == 1) begin
            thermal_acc = thermal_acc + SUM_BITS'(it.sample);
            // empty window when limits cross: every sample is outside
            if (cfg_enable && wd_armed && (it.sample < cfg_low || it.sample > cfg_high)) begin
               r.alarm  = 1'b1;
               wd_armed = 1'b0;
            end
         end else begin
            angle_acc = angle_acc + SUM_BITS'(it.sample);
         end
         scan_pos++;
         if (scan_pos >= BLOCK_LEN) begin
            angle_held      = FIELD_BITS'(angle_acc >> LOG2);
            thermal_held    = FIELD_BITS'(thermal_acc >> LOG2);
            angle_acc       = '0;
            thermal_acc     = '0;
            scan_pos        = 0;
            r.average_valid = 1'b1;
         end
      end
      r.angle_average   = angle_held;
      r.thermal_average = thermal_held;
      r.armed           = wd_armed;
      return r;
   endfunction

   function automatic void flag_error(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch on %s at result %0d: expected %0d, got %0d",
                  what, results_seen, want, got);
   endfunction

   function automatic item_type sample_item(logic [FIELD_BITS-1:0] s);
      item_type it;
      it.mode   = MODE_SAMPLE;
      it.sample = s;
      return it;
   endfunction

   function automatic item_type rearm_item();
      item_type it;
      it.mode   = MODE_REARM;
      it.sample = FIELD_BITS'($urandom);   // ignored by the block
      return it;
   endfunction

   // values clustered at the extremes and around the current window edges
   function automatic logic [FIELD_BITS-1:0] pick_sample();
      int v;
      case ($urandom_range(0, 9))
         0:       v = 0;
         1:       v = 4095;
         2:       v = int'(cfg_low) + int'($urandom_range(0, 2)) - 1;
         3:       v = int'(cfg_high) + int'($urandom_range(0, 2)) - 1;
         default: v = $urandom_range(0, 4095);
      endcase
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return FIELD_BITS'(v);
   endfunction

   // setup cycle then access cycle; the register takes the value on the access edge
   task automatic csr_write(logic [1:0] idx, logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_LOW_LIMIT:       cfg_low    = value[FIELD_BITS-1:0];
         REG_HIGH_LIMIT:      cfg_high   = value[FIELD_BITS-1:0];
         REG_WATCHDOG_ENABLE: cfg_enable = value[0];
         default: ;
      endcase
   endtask

   // every item gives one result, so an empty expectation store means idle
   task automatic wait_drained();
      @(negedge clock);
      while (pending_items.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // sender: offers the next pending item, with random gaps
   always @(posedge clock) begin
      logic offer;
      offer = 1'b0;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_results.push_back(average_watchdog_step(current_item));
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
            end else if (pending_items.size() != 0) begin
               if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
                  gap_left <= $urandom_range(0, 3);
               end else begin
                  current_item = pending_items.pop_front();
                  offer = 1'b1;
               end
            end
            req_tvalid <= offer;
            if (offer) begin
               req_tdata <= REQ_DATA_BITS'(current_item.sample);
               req_tuser <= current_item.mode;
            end
         end
      end
   end

   // receiver: checks each result against the oldest expectation, stalls at random
   always @(posedge clock) begin
      scan_result_type want;
      logic ready;
      ready = 1'b1;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            // one long hold-off so the block backs up into its input
            if (results_seen == HOLD_AT)
               hold_left = HOLD_CYCLES;
            if (expected_results.size() == 0) begin
               flag_error("unexpected result", 0, rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tuser != want.average_valid)
                  flag_error("average_valid", want.average_valid, rsp_tuser);
               if (rsp_tdata[11:0] != want.angle_average)
                  flag_error("angle_average", want.angle_average, rsp_tdata[11:0]);
               if (rsp_tdata[23:12] != want.thermal_average)
                  flag_error("thermal_average", want.thermal_average, rsp_tdata[23:12]);
               if (rsp_tdata[24] != want.alarm)
                  flag_error("alarm", want.alarm, rsp_tdata[24]);
               if (rsp_tdata[25] != want.armed)
                  flag_error("armed", want.armed, rsp_tdata[25]);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            ready = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            ready = 1'b0;
         end else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
            stall_left = $urandom_range(0, 3);
            ready = 1'b0;
         end
         rsp_tready <= ready;
      end
   end

   // ends a hung run
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      logic [FIELD_BITS-1:0] a;
      logic [FIELD_BITS-1:0] b;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      gap_odds   = 6;
      stall_odds = 6;

      // reset settings, watchdog off: extreme samples and a full block
      pending_items.push_back(sample_item(12'd0));
      pending_items.push_back(sample_item(12'd4095));
      pending_items.push_back(sample_item(12'd4095));
      pending_items.push_back(rearm_item());
      pending_items.push_back(sample_item(12'd0));
      pending_items.push_back(sample_item(12'd4095));
      pending_items.push_back(sample_item(12'd4095));
      pending_items.push_back(sample_item(12'd4095));
      pending_items.push_back(sample_item(12'd4095));
      wait_drained();

      // window 100..3000 on: trip, stay quiet while disarmed, rearm, trip on the last sample
      csr_write(REG_LOW_LIMIT, 32'd100);
      csr_write(REG_HIGH_LIMIT, 32'd3000);
      csr_write(REG_WATCHDOG_ENABLE, 32'd1);
      pending_items.push_back(sample_item(12'd5));
      pending_items.push_back(sample_item(12'd99));
      pending_items.push_back(sample_item(12'd5));
      pending_items.push_back(sample_item(12'd3001));
      pending_items.push_back(rearm_item());
      pending_items.push_back(sample_item(12'd0));
      pending_items.push_back(sample_item(12'd3000));
      pending_items.push_back(sample_item(12'd0));
      pending_items.push_back(sample_item(12'd3001));
      wait_drained();

      // crossed limits with the watchdog off, rearm while disabled
      csr_write(REG_LOW_LIMIT, 32'd2000);
      csr_write(REG_HIGH_LIMIT, 32'd1000);
      csr_write(REG_WATCHDOG_ENABLE, 32'd0);
      pending_items.push_back(rearm_item());
      pending_items.push_back(sample_item(12'd7));
      pending_items.push_back(sample_item(12'd1500));
      wait_drained();

      // enabling now must use the earlier rearm; crossed window always trips
      csr_write(REG_WATCHDOG_ENABLE, 32'd1);
      pending_items.push_back(sample_item(12'd7));
      pending_items.push_back(sample_item(12'd1500));
      wait_drained();

      // random phases, each with its own register settings
      for (int k = 0; k < RAND_PHASES; k++) begin
         a = FIELD_BITS'($urandom_range(0, 4095));
         b = FIELD_BITS'($urandom_range(0, 4095));
         case (k)
            0: begin a = 12'd0;    b = 12'd4095; end   // widest window
            1: begin a = 12'd4095; b = 12'd0;    end   // fully crossed
            2, 5: ;                                     // any order
            default: if (a > b) begin a ^= b; b ^= a; a ^= b; end
         endcase
         csr_write(REG_LOW_LIMIT, 32'(a));
         csr_write(REG_HIGH_LIMIT, 32'(b));
         csr_write(REG_WATCHDOG_ENABLE, (k == 2) ? 32'd0 : 32'(($urandom_range(0, 7) != 0)));

         // a stretch with no idling, and none at all in the final phase
         gap_odds   = (k == 3 || k == RAND_PHASES - 1) ? 0 : $urandom_range(3, 8);
         stall_odds = (k == 3 || k == RAND_PHASES - 1) ? 0 : $urandom_range(3, 8);

         for (int n = 0; n < RAND_ITEMS; n++) begin
            if ($urandom_range(0, 11) == 0)
               pending_items.push_back(rearm_item());
            else
               pending_items.push_back(sample_item(pick_sample()));
         end
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (expected_results.size() != 0)
         flag_error("results never delivered", 0, expected_results.size());

      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
